// ===== rtl/etw_pkg.sv =====
// ----------------------------------------------------------------------------
// Ego-to-world transform package
// Request and response types, the CORDIC pipeline word and fixed constants.
// ----------------------------------------------------------------------------
package etw_pkg;

    localparam int W_CS    = 33;
    localparam int W_PROD  = 65;
    localparam int W_SUM   = 67;
    localparam int W_WORLD = 38;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
        logic signed [15:0] robot_heading;
    } t_req;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic               overflow;
    } t_rsp;

    typedef struct packed {
        logic signed [W_CS-1:0] x;
        logic signed [W_CS-1:0] y;
        logic signed [W_CS-1:0] z;
        logic                   flip;
        logic signed [31:0]     px;
        logic signed [31:0]     py;
        logic signed [31:0]     rx;
        logic signed [31:0]     ry;
    } t_cell_data;

    localparam logic signed [W_CS-1:0] C_GAIN    = 33'sd652032874;
    localparam logic signed [31:0]     C_QUARTER = 32'sd1073741824;
    localparam logic signed [W_SUM-1:0] C_ROUND  = 67'sd536870912;
    localparam logic signed [W_WORLD-1:0] C_MAX  = 38'sd2147483647;
    localparam logic signed [W_WORLD-1:0] C_MIN  = -38'sd2147483648;

    localparam logic signed [W_CS-1:0] C_ATAN [32] = '{
        33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
        33'sd42667331,  33'sd21354465,  33'sd10679838,  33'sd5340245,
        33'sd2670163,   33'sd1335087,   33'sd667544,    33'sd333772,
        33'sd166886,    33'sd83443,     33'sd41722,     33'sd20861,
        33'sd10430,     33'sd5215,      33'sd2608,      33'sd1304,
        33'sd652,       33'sd326,       33'sd163,       33'sd81,
        33'sd41,        33'sd20,        33'sd10,        33'sd5,
        33'sd3,         33'sd1,         33'sd1,         33'sd0
    };

endpackage

// ===== rtl/ego_to_world_point_transform_top.sv =====
// ----------------------------------------------------------------------------
// Ego-to-world point transform
// Rotates a robot-relative Q16.16 point by the robot heading, using a chain
// of CORDIC cells for sine and cosine, and adds the robot world position.
//
//   Channel    Valid          Ready          Payload
//   request    i_req_valid    o_req_ready    i_req (t_req)
//   response   o_rsp_valid    i_rsp_ready    o_rsp (t_rsp)
//
// One request is accepted per cycle while o_req_ready is high; the result passes
// through one register per CORDIC cell, then the multiply, sum and
// saturate stages. Every stage has its own valid bit, so empty stages fill
// while the response is stalled. Reset clears all valid bits.
// ----------------------------------------------------------------------------
module ego_to_world_point_transform_top
    import etw_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_cell_data w_d   [CORDIC_STAGES+1];
    logic       w_vld [CORDIC_STAGES+1];
    logic       w_rdy [CORDIC_STAGES+1];

    logic signed [31:0] w_z0;
    logic               w_fold;

    assign w_z0   = {i_req.robot_heading, 16'h0000};
    assign w_fold = (w_z0 > C_QUARTER) || (w_z0 < -C_QUARTER);

    always_comb begin
        w_d[0].x    = C_GAIN;
        w_d[0].y    = '0;
        w_d[0].z    = w_fold ? W_CS'($signed({~w_z0[31], w_z0[30:0]})) : W_CS'(w_z0);
        w_d[0].flip = w_fold;
        w_d[0].px   = i_req.point_x;
        w_d[0].py   = i_req.point_y;
        w_d[0].rx   = i_req.robot_x;
        w_d[0].ry   = i_req.robot_y;
    end

    assign w_vld[0]    = i_req_valid;
    assign o_req_ready = w_rdy[0];

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        etw_cell #(
            .K(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .i_d     (w_d[g]),
            .o_ready (w_rdy[g]),
            .o_valid (w_vld[g+1]),
            .o_d     (w_d[g+1]),
            .i_ready (w_rdy[g+1])
        );
    end

    etw_post u_post (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_vld[CORDIC_STAGES]),
        .i_d         (w_d[CORDIC_STAGES]),
        .o_ready     (w_rdy[CORDIC_STAGES]),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp),
        .i_rsp_ready (i_rsp_ready)
    );

endmodule

// ===== rtl/etw_cell.sv =====
// ----------------------------------------------------------------------------
// Ego-to-world CORDIC cell
// One rotation-mode CORDIC iteration with its own valid bit and stall logic.
// ----------------------------------------------------------------------------
module etw_cell
    import etw_pkg::*;
#(
    parameter int K = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cell_data i_d,
    output logic       o_ready,
    output logic       o_valid,
    output t_cell_data o_d,
    input  logic       i_ready
);

    localparam int SHIFT = K % 32;

    logic       r_valid;
    t_cell_data r_d;
    t_cell_data n_d;
    logic signed [W_CS-1:0] w_dx;
    logic signed [W_CS-1:0] w_dy;

    assign o_ready = ~r_valid | i_ready;
    assign o_valid = r_valid;
    assign o_d     = r_d;

    assign w_dx = i_d.y >>> SHIFT;
    assign w_dy = i_d.x >>> SHIFT;

    always_comb begin
        n_d = i_d;
        if (!i_d.z[W_CS-1]) begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.z = i_d.z - C_ATAN[SHIFT];
        end else begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.z = i_d.z + C_ATAN[SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_d <= n_d;
        end
    end

endmodule

// ===== rtl/etw_post.sv =====
// ----------------------------------------------------------------------------
// Ego-to-world rotate and translate back end
// Multiplies the point by cosine and sine, rounds, adds the robot position
// and saturates, over three registered stages.
// ----------------------------------------------------------------------------
module etw_post
    import etw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cell_data i_d,
    output logic       o_ready,
    output logic       o_rsp_valid,
    output t_rsp       o_rsp,
    input  logic       i_rsp_ready
);

    logic r_m_vld;
    logic r_s_vld;
    logic r_o_vld;
    logic w_m_rdy;
    logic w_s_rdy;
    logic w_o_rdy;

    logic signed [W_PROD-1:0] r_cpx;
    logic signed [W_PROD-1:0] r_spy;
    logic signed [W_PROD-1:0] r_spx;
    logic signed [W_PROD-1:0] r_cpy;
    logic                     r_flip;
    logic signed [31:0]       r_m_rx;
    logic signed [31:0]       r_m_ry;

    logic signed [W_SUM-1:0]  r_sx;
    logic signed [W_SUM-1:0]  r_sy;
    logic signed [31:0]       r_s_rx;
    logic signed [31:0]       r_s_ry;
    logic signed [W_SUM-1:0]  n_sx;
    logic signed [W_SUM-1:0]  n_sy;

    logic signed [W_WORLD-1:0] w_ax;
    logic signed [W_WORLD-1:0] w_ay;
    t_rsp r_rsp;
    t_rsp n_rsp;

    assign w_o_rdy     = ~r_o_vld | i_rsp_ready;
    assign w_s_rdy     = ~r_s_vld | w_o_rdy;
    assign w_m_rdy     = ~r_m_vld | w_s_rdy;
    assign o_ready     = w_m_rdy;
    assign o_rsp_valid = r_o_vld;
    assign o_rsp       = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_s_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (w_m_rdy) begin
                r_m_vld <= i_valid;
            end
            if (w_s_rdy) begin
                r_s_vld <= r_m_vld;
            end
            if (w_o_rdy) begin
                r_o_vld <= r_s_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m_rdy && i_valid) begin
            r_cpx  <= W_PROD'(i_d.x * i_d.px);
            r_spy  <= W_PROD'(i_d.y * i_d.py);
            r_spx  <= W_PROD'(i_d.y * i_d.px);
            r_cpy  <= W_PROD'(i_d.x * i_d.py);
            r_flip <= i_d.flip;
            r_m_rx <= i_d.rx;
            r_m_ry <= i_d.ry;
        end
    end

    always_comb begin
        if (r_flip) begin
            n_sx = W_SUM'(r_spy) - W_SUM'(r_cpx) + C_ROUND;
            n_sy = C_ROUND - W_SUM'(r_spx) - W_SUM'(r_cpy);
        end else begin
            n_sx = W_SUM'(r_cpx) - W_SUM'(r_spy) + C_ROUND;
            n_sy = W_SUM'(r_spx) + W_SUM'(r_cpy) + C_ROUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_rdy && r_m_vld) begin
            r_sx   <= n_sx;
            r_sy   <= n_sy;
            r_s_rx <= r_m_rx;
            r_s_ry <= r_m_ry;
        end
    end

    assign w_ax = W_WORLD'(r_sx >>> 30) + W_WORLD'(r_s_rx);
    assign w_ay = W_WORLD'(r_sy >>> 30) + W_WORLD'(r_s_ry);

    always_comb begin
        n_rsp.overflow = 1'b0;
        if (w_ax > C_MAX) begin
            n_rsp.world_x  = 32'sh7fffffff;
            n_rsp.overflow = 1'b1;
        end else if (w_ax < C_MIN) begin
            n_rsp.world_x  = 32'sh80000000;
            n_rsp.overflow = 1'b1;
        end else begin
            n_rsp.world_x = w_ax[31:0];
        end
        if (w_ay > C_MAX) begin
            n_rsp.world_y  = 32'sh7fffffff;
            n_rsp.overflow = 1'b1;
        end else if (w_ay < C_MIN) begin
            n_rsp.world_y  = 32'sh80000000;
            n_rsp.overflow = 1'b1;
        end else begin
            n_rsp.world_y = w_ay[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_rdy && r_s_vld) begin
            r_rsp <= n_rsp;
        end
    end

endmodule
